/* rtl/gls_pkg.sv */
package gls_pkg;

    localparam int MAX_ORDER  = 8;
    localparam int Q_W        = 32;
    localparam int FRAC_W     = 16;
    localparam int ORD_W      = 4;
    localparam int STS_W      = 2;
    localparam int ROOT_IDX_W = 3;

    localparam int IDX_W   = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int CNT_W   = $clog2(MAX_ORDER + 1);
    localparam int DEPTH   = MAX_ORDER * (MAX_ORDER + 1);
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int WIDE_W  = 2 * CNT_W + 2;

    localparam int QN_W       = Q_W + FRAC_W;
    localparam int DIV_STEPS  = QN_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    localparam logic [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    typedef enum logic [STS_W-1:0] {
        ST_UNIQUE = 2'd0,
        ST_MANY   = 2'd1,
        ST_NONE   = 2'd2
    } sol_status_t;

    typedef enum logic [2:0] {
        WS_INPUT,
        WS_READ,
        WS_SWAP,
        WS_QUOT,
        WS_DIFF
    } wsel_t;

    typedef enum logic [4:0] {
        S_LOAD,
        S_PV_START,
        S_PV_RD,
        S_PV_CMP,
        S_SW_RDA,
        S_SW_RDB,
        S_SW_WRA,
        S_SW_WRB,
        S_PIV_RD,
        S_PIV_CHK,
        S_ZR_RD,
        S_ZR_CHK,
        S_ZOUT,
        S_NM_RD,
        S_NM_DIV,
        S_NM_WAIT,
        S_EL_FRD,
        S_EL_FLAT,
        S_EL_RDA,
        S_EL_MUL,
        S_EL_SUB,
        S_BS_RD,
        S_BS_XLAT,
        S_BS_RDA,
        S_BS_MUL,
        S_BS_SUB,
        S_BS_WR,
        S_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              rd;
        logic              we;
        wsel_t             wsel;
        logic              tmp_load;
        logic              piv_load;
        logic              f_load;
        logic              x_load;
        logic              x_sub;
        logic              mul;
        logic              bs;
        logic              clr_mag;
        logic              take_mag;
        logic              clr_nz;
        logic              chk_nz;
        logic              div_start;
        logic              sol_we;
        logic [IDX_W-1:0]  sol_idx;
        logic              out_load;
        logic              out_zero;
        logic              out_last;
    } gls_cmd_t;

    typedef struct packed {
        logic mag_gt;
        logic rd_zero;
        logic nz;
        logic div_done;
        logic out_free;
    } gls_sts_t;

    function automatic logic [Q_W-1:0] q_mag(input logic [Q_W-1:0] a);
        return a[Q_W-1] ? (~a + 1'b1) : a;
    endfunction

    function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] row,
                                                    input logic [CNT_W-1:0] col,
                                                    input logic [CNT_W-1:0] n);
        logic [WIDE_W-1:0] full;
        full = WIDE_W'(row) * (WIDE_W'(n) + 1'b1) + WIDE_W'(col);
        return full[ADDR_W-1:0];
    endfunction

endpackage

/* rtl/gauss_linear_system_solver.sv */
// Channel   Handshake            Payload
// in        in_valid / in_stall  value (one matrix element, row-major, n+1 per row)
// out       out_valid / out_stall root, root_index, last, status
// cfg       cfg_we               cfg_data (order)
//
// Elements load at one beat per cycle unless cfg_we stalls them; the solve starts
// after the last one. The bit-serial divider finishes each normalised element
// before the next is read; eliminated elements use the single matrix store port.
// Reset brings the order to 8 and empties the load; no clearing pass is needed.
// A stalled result is held in the output register while the solve waits.
module gauss_linear_system_solver (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [gls_pkg::ORD_W-1:0]      cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [gls_pkg::Q_W-1:0]        value,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [gls_pkg::Q_W-1:0]        root,
    output logic [gls_pkg::ROOT_IDX_W-1:0] root_index,
    output logic                           last,
    output logic [gls_pkg::STS_W-1:0]      status
);
    import gls_pkg::*;

    gls_cmd_t cmd;
    gls_sts_t sts;

    gls_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    gls_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (value),
        .cmd        (cmd),
        .sts        (sts),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .root       (root),
        .root_index (root_index),
        .last       (last),
        .status     (status)
    );

endmodule

/* rtl/gls_div.sv */
module gls_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [gls_pkg::Q_W-1:0]    num,
    input  logic [gls_pkg::Q_W-1:0]    den,
    output logic                       busy,
    output logic [gls_pkg::Q_W-1:0]    quot
);
    import gls_pkg::*;

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 neg_reg, neg_next;
    logic [Q_W-1:0]       den_reg, den_next;
    logic [Q_W-1:0]       rem_reg, rem_next;
    logic [QN_W-1:0]      qn_reg, qn_next;
    logic [Q_W:0]         trial;

    // One quotient bit per cycle, restoring division on magnitudes.
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        qn_next   = qn_reg;
        trial     = {rem_reg, qn_reg[QN_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            neg_next  = num[Q_W-1] ^ den[Q_W-1];
            den_next  = q_mag(den);
            rem_next  = '0;
            qn_next   = {q_mag(num), {FRAC_W{1'b0}}};
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = Q_W'(trial - {1'b0, den_reg});
                qn_next  = {qn_reg[QN_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[Q_W-1:0];
                qn_next  = {qn_reg[QN_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        qn_reg  <= qn_next;
    end

    always_comb
    begin
        if (!neg_reg)
        begin
            quot = (qn_reg[QN_W-1:Q_W-1] != '0) ? Q_MAX : qn_reg[Q_W-1:0];
        end
        else if ((qn_reg[QN_W-1:Q_W] != '0) || (qn_reg[Q_W-1] && (qn_reg[Q_W-2:0] != '0)))
        begin
            quot = Q_MIN;
        end
        else
        begin
            quot = ~qn_reg[Q_W-1:0] + 1'b1;
        end
    end

    assign busy = busy_reg;

endmodule

/* rtl/gls_dp.sv */
module gls_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [gls_pkg::Q_W-1:0]       value,
    input  gls_pkg::gls_cmd_t             cmd,
    output gls_pkg::gls_sts_t             sts,
    input  logic                          out_stall,
    output logic                          out_valid,
    output logic [gls_pkg::Q_W-1:0]       root,
    output logic [gls_pkg::ROOT_IDX_W-1:0] root_index,
    output logic                          last,
    output logic [gls_pkg::STS_W-1:0]     status
);
    import gls_pkg::*;

    logic [Q_W-1:0]    mem [DEPTH];
    logic [Q_W-1:0]    rdata_reg;
    logic [Q_W-1:0]    tmp_reg;
    logic [Q_W-1:0]    piv_reg;
    logic [Q_W-1:0]    f_reg;
    logic [Q_W-1:0]    x_reg;
    logic [Q_W-1:0]    best_mag_reg;
    logic              nz_reg;
    logic [2*Q_W-1:0]  prod_reg;
    logic [Q_W-1:0]    sol_reg [MAX_ORDER];

    logic              out_valid_reg;
    logic [Q_W-1:0]    root_reg;
    logic [ROOT_IDX_W-1:0] root_index_reg;
    logic              last_reg;
    sol_status_t       status_reg;

    logic [Q_W-1:0]    wdata;
    logic [Q_W-1:0]    rd_mag;
    logic [Q_W-1:0]    mul_b;
    logic [Q_W-1:0]    sol_rd;
    logic [QN_W-1:0]   scaled;
    logic [Q_W-1:0]    qprod;
    logic [Q_W-1:0]    minuend;
    logic [Q_W:0]      diff_wide;
    logic [Q_W-1:0]    diff;
    logic [Q_W-1:0]    quot;
    logic              div_busy;

    gls_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (rdata_reg),
        .den   (piv_reg),
        .busy  (div_busy),
        .quot  (quot)
    );

    assign rd_mag  = q_mag(rdata_reg);
    assign sol_rd  = sol_reg[cmd.sol_idx];
    assign mul_b   = cmd.bs ? sol_rd : f_reg;
    assign minuend = cmd.bs ? x_reg : rdata_reg;

    // Dropping the low fraction bits of a two's complement product rounds towards minus infinity.
    assign scaled = prod_reg[2*Q_W-1:FRAC_W];

    always_comb
    begin
        if (scaled[QN_W-1:Q_W-1] == '0 || scaled[QN_W-1:Q_W-1] == '1)
        begin
            qprod = scaled[Q_W-1:0];
        end
        else
        begin
            qprod = scaled[QN_W-1] ? Q_MIN : Q_MAX;
        end
        diff_wide = {minuend[Q_W-1], minuend} - {qprod[Q_W-1], qprod};
        if (diff_wide[Q_W] != diff_wide[Q_W-1])
        begin
            diff = diff_wide[Q_W] ? Q_MIN : Q_MAX;
        end
        else
        begin
            diff = diff_wide[Q_W-1:0];
        end
    end

    always_comb
    begin
        case (cmd.wsel)
            WS_INPUT: wdata = value;
            WS_READ:  wdata = rdata_reg;
            WS_SWAP:  wdata = tmp_reg;
            WS_QUOT:  wdata = quot;
            WS_DIFF:  wdata = diff;
            default:  wdata = rdata_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            mem[cmd.addr] <= wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[cmd.addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tmp_load)
        begin
            tmp_reg <= rdata_reg;
        end
        if (cmd.piv_load)
        begin
            piv_reg <= rdata_reg;
        end
        if (cmd.f_load)
        begin
            f_reg <= rdata_reg;
        end
        if (cmd.x_load)
        begin
            x_reg <= rdata_reg;
        end
        else if (cmd.x_sub)
        begin
            x_reg <= diff;
        end
        if (cmd.mul)
        begin
            prod_reg <= (2*Q_W)'($signed(rdata_reg) * $signed(mul_b));
        end
        if (cmd.clr_mag)
        begin
            best_mag_reg <= '0;
        end
        else if (cmd.take_mag && sts.mag_gt)
        begin
            best_mag_reg <= rd_mag;
        end
        if (cmd.clr_nz)
        begin
            nz_reg <= 1'b0;
        end
        else if (cmd.chk_nz && (rdata_reg != '0))
        begin
            nz_reg <= 1'b1;
        end
        if (cmd.sol_we)
        begin
            sol_reg[cmd.sol_idx] <= x_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            root_reg       <= cmd.out_zero ? '0 : sol_rd;
            root_index_reg <= cmd.out_zero ? '0
                                           : ROOT_IDX_W'({{ROOT_IDX_W{1'b0}}, cmd.sol_idx});
            last_reg       <= cmd.out_last;
            if (!cmd.out_zero)
            begin
                status_reg <= ST_UNIQUE;
            end
            else
            begin
                status_reg <= nz_reg ? ST_NONE : ST_MANY;
            end
        end
    end

    assign sts.mag_gt   = rd_mag > best_mag_reg;
    assign sts.rd_zero  = rdata_reg == '0;
    assign sts.nz       = nz_reg;
    assign sts.div_done = !div_busy;
    assign sts.out_free = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign root       = root_reg;
    assign root_index = root_index_reg;
    assign last       = last_reg;
    assign status     = status_reg;

endmodule

/* rtl/gls_ctrl.sv */
module gls_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [gls_pkg::ORD_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  gls_pkg::gls_sts_t           sts,
    output gls_pkg::gls_cmd_t           cmd
);
    import gls_pkg::*;

    ctrl_state_t        state_reg, state_next;
    logic [ORD_W-1:0]   order_reg, order_next;
    logic [ADDR_W-1:0]  load_cnt_reg, load_cnt_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic [IDX_W-1:0]   r_reg, r_next;
    logic [IDX_W-1:0]   best_reg, best_next;
    logic [CNT_W-1:0]   c_reg, c_next;

    logic [CNT_W-1:0]   n;
    logic [CNT_W-1:0]   n_m1;
    logic [IDX_W-1:0]   last_row;
    logic [WIDE_W-1:0]  total_wide;
    logic [ADDR_W-1:0]  total_m1;

    always_comb
    begin
        if (order_reg == '0)
        begin
            n = CNT_W'(1);
        end
        else if (order_reg > ORD_W'(MAX_ORDER))
        begin
            n = CNT_W'(MAX_ORDER);
        end
        else
        begin
            n = CNT_W'(order_reg);
        end
    end

    assign n_m1       = n - 1'b1;
    assign last_row   = IDX_W'(n_m1);
    assign total_wide = WIDE_W'(n) * (WIDE_W'(n) + 1'b1) - 1'b1;
    assign total_m1   = total_wide[ADDR_W-1:0];

    always_comb
    begin
        state_next    = state_reg;
        order_next    = order_reg;
        load_cnt_next = load_cnt_reg;
        k_next        = k_reg;
        r_next        = r_reg;
        best_next     = best_reg;
        c_next        = c_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (cfg_we)
                begin
                    order_next    = cfg_data;
                    load_cnt_next = '0;
                end
                else if (in_valid)
                begin
                    if (load_cnt_reg == total_m1)
                    begin
                        load_cnt_next = '0;
                        k_next        = '0;
                        state_next    = S_PV_START;
                    end
                    else
                    begin
                        load_cnt_next = load_cnt_reg + 1'b1;
                    end
                end
            end
            S_PV_START:
            begin
                r_next     = k_reg;
                best_next  = k_reg;
                state_next = S_PV_RD;
            end
            S_PV_RD:
            begin
                state_next = S_PV_CMP;
            end
            S_PV_CMP:
            begin
                if (sts.mag_gt)
                begin
                    best_next = r_reg;
                end
                if (r_reg == last_row)
                begin
                    c_next = '0;
                    if (best_next != k_reg)
                    begin
                        state_next = S_SW_RDA;
                    end
                    else
                    begin
                        state_next = S_PIV_RD;
                    end
                end
                else
                begin
                    r_next     = r_reg + 1'b1;
                    state_next = S_PV_RD;
                end
            end
            S_SW_RDA:
            begin
                state_next = S_SW_RDB;
            end
            S_SW_RDB:
            begin
                state_next = S_SW_WRA;
            end
            S_SW_WRA:
            begin
                state_next = S_SW_WRB;
            end
            S_SW_WRB:
            begin
                if (c_reg == n)
                begin
                    state_next = S_PIV_RD;
                end
                else
                begin
                    c_next     = c_reg + 1'b1;
                    state_next = S_SW_RDA;
                end
            end
            S_PIV_RD:
            begin
                state_next = S_PIV_CHK;
            end
            S_PIV_CHK:
            begin
                if (sts.rd_zero)
                begin
                    c_next     = '0;
                    state_next = S_ZR_RD;
                end
                else
                begin
                    c_next     = CNT_W'(k_reg);
                    state_next = S_NM_RD;
                end
            end
            S_ZR_RD:
            begin
                state_next = S_ZR_CHK;
            end
            S_ZR_CHK:
            begin
                if (c_reg == n)
                begin
                    state_next = S_ZOUT;
                end
                else
                begin
                    c_next     = c_reg + 1'b1;
                    state_next = S_ZR_RD;
                end
            end
            S_ZOUT:
            begin
                if (sts.out_free)
                begin
                    state_next = S_LOAD;
                end
            end
            S_NM_RD:
            begin
                state_next = S_NM_DIV;
            end
            S_NM_DIV:
            begin
                state_next = S_NM_WAIT;
            end
            S_NM_WAIT:
            begin
                if (sts.div_done)
                begin
                    if (c_reg != n)
                    begin
                        c_next     = c_reg + 1'b1;
                        state_next = S_NM_RD;
                    end
                    else if (k_reg == last_row)
                    begin
                        r_next     = last_row;
                        state_next = S_BS_RD;
                    end
                    else
                    begin
                        r_next     = k_reg + 1'b1;
                        state_next = S_EL_FRD;
                    end
                end
            end
            S_EL_FRD:
            begin
                state_next = S_EL_FLAT;
            end
            S_EL_FLAT:
            begin
                c_next     = CNT_W'(k_reg);
                state_next = S_EL_RDA;
            end
            S_EL_RDA:
            begin
                state_next = S_EL_MUL;
            end
            S_EL_MUL:
            begin
                state_next = S_EL_SUB;
            end
            S_EL_SUB:
            begin
                if (c_reg != n)
                begin
                    c_next     = c_reg + 1'b1;
                    state_next = S_EL_RDA;
                end
                else if (r_reg == last_row)
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_PV_START;
                end
                else
                begin
                    r_next     = r_reg + 1'b1;
                    state_next = S_EL_FRD;
                end
            end
            S_BS_RD:
            begin
                state_next = S_BS_XLAT;
            end
            S_BS_XLAT:
            begin
                if (r_reg == last_row)
                begin
                    state_next = S_BS_WR;
                end
                else
                begin
                    c_next     = CNT_W'(r_reg) + 1'b1;
                    state_next = S_BS_RDA;
                end
            end
            S_BS_RDA:
            begin
                state_next = S_BS_MUL;
            end
            S_BS_MUL:
            begin
                state_next = S_BS_SUB;
            end
            S_BS_SUB:
            begin
                if (c_reg == n_m1)
                begin
                    state_next = S_BS_WR;
                end
                else
                begin
                    c_next     = c_reg + 1'b1;
                    state_next = S_BS_RDA;
                end
            end
            S_BS_WR:
            begin
                if (r_reg == '0)
                begin
                    c_next     = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    r_next     = r_reg - 1'b1;
                    state_next = S_BS_RD;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    if (c_reg == n_m1)
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        c_next = c_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.wsel = WS_INPUT;
        in_stall = 1'b1;
        case (state_reg)
            S_LOAD:
            begin
                // A register write takes the cycle, so no beat is taken alongside it.
                in_stall = cfg_we;
                cmd.we   = in_valid && !cfg_we;
                cmd.addr = load_cnt_reg;
            end
            S_PV_START:
            begin
                cmd.clr_mag = 1'b1;
            end
            S_PV_RD:
            begin
                cmd.rd   = 1'b1;
                cmd.addr = elem_addr(r_reg, CNT_W'(k_reg), n);
            end
            S_PV_CMP:
            begin
                cmd.take_mag = 1'b1;
            end
            S_SW_RDA:
            begin
                cmd.rd   = 1'b1;
                cmd.addr = elem_addr(k_reg, c_reg, n);
            end
            S_SW_RDB:
            begin
                cmd.rd       = 1'b1;
                cmd.tmp_load = 1'b1;
                cmd.addr     = elem_addr(best_reg, c_reg, n);
            end
            S_SW_WRA:
            begin
                cmd.we   = 1'b1;
                cmd.wsel = WS_READ;
                cmd.addr = elem_addr(k_reg, c_reg, n);
            end
            S_SW_WRB:
            begin
                cmd.we   = 1'b1;
                cmd.wsel = WS_SWAP;
                cmd.addr = elem_addr(best_reg, c_reg, n);
            end
            S_PIV_RD:
            begin
                cmd.rd   = 1'b1;
                cmd.addr = elem_addr(k_reg, CNT_W'(k_reg), n);
            end
            S_PIV_CHK:
            begin
                cmd.piv_load = 1'b1;
                cmd.clr_nz   = 1'b1;
            end
            S_ZR_RD:
            begin
                cmd.rd   = 1'b1;
                cmd.addr = elem_addr(k_reg, c_reg, n);
            end
            S_ZR_CHK:
            begin
                cmd.chk_nz = 1'b1;
            end
            S_ZOUT:
            begin
                cmd.out_load = sts.out_free;
                cmd.out_zero = 1'b1;
                cmd.out_last = 1'b1;
            end
            S_NM_RD:
            begin
                cmd.rd   = 1'b1;
                cmd.addr = elem_addr(k_reg, c_reg, n);
            end
            S_NM_DIV:
            begin
                cmd.div_start = 1'b1;
            end
            S_NM_WAIT:
            begin
                cmd.we   = sts.div_done;
                cmd.wsel = WS_QUOT;
                cmd.addr = elem_addr(k_reg, c_reg, n);
            end
            S_EL_FRD:
            begin
                cmd.rd   = 1'b1;
                cmd.addr = elem_addr(r_reg, CNT_W'(k_reg), n);
            end
            S_EL_FLAT:
            begin
                cmd.f_load = 1'b1;
            end
            S_EL_RDA:
            begin
                cmd.rd   = 1'b1;
                cmd.addr = elem_addr(k_reg, c_reg, n);
            end
            S_EL_MUL:
            begin
                cmd.mul  = 1'b1;
                cmd.rd   = 1'b1;
                cmd.addr = elem_addr(r_reg, c_reg, n);
            end
            S_EL_SUB:
            begin
                cmd.we   = 1'b1;
                cmd.wsel = WS_DIFF;
                cmd.addr = elem_addr(r_reg, c_reg, n);
            end
            S_BS_RD:
            begin
                cmd.rd   = 1'b1;
                cmd.addr = elem_addr(r_reg, n, n);
            end
            S_BS_XLAT:
            begin
                cmd.x_load = 1'b1;
            end
            S_BS_RDA:
            begin
                cmd.rd   = 1'b1;
                cmd.addr = elem_addr(r_reg, c_reg, n);
            end
            S_BS_MUL:
            begin
                cmd.mul     = 1'b1;
                cmd.bs      = 1'b1;
                cmd.sol_idx = c_reg[IDX_W-1:0];
            end
            S_BS_SUB:
            begin
                cmd.bs    = 1'b1;
                cmd.x_sub = 1'b1;
            end
            S_BS_WR:
            begin
                cmd.sol_we  = 1'b1;
                cmd.sol_idx = r_reg;
            end
            S_EMIT:
            begin
                cmd.sol_idx  = c_reg[IDX_W-1:0];
                cmd.out_load = sts.out_free;
                cmd.out_last = c_reg == n_m1;
            end
            default:
            begin
                cmd.we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_LOAD;
            order_reg    <= ORD_W'(MAX_ORDER);
            load_cnt_reg <= '0;
            k_reg        <= '0;
            r_reg        <= '0;
            best_reg     <= '0;
            c_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            order_reg    <= order_next;
            load_cnt_reg <= load_cnt_next;
            k_reg        <= k_next;
            r_reg        <= r_next;
            best_reg     <= best_next;
            c_reg        <= c_next;
        end
    end

`ifndef SYNTHESIS
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded while the output register is still held");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> sts.div_done)
        else $error("divider started while busy");

    a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> (load_cnt_reg <= total_m1))
        else $error("load count beyond the system size");

    a_last_ret: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && cmd.out_load && cmd.out_last) |=> (state_reg == S_LOAD))
        else $error("no return to loading after the last root");

    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.rd && cmd.we))
        else $error("matrix store read and written in the same cycle");
`endif

endmodule
